@@ design/fat16_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// FAT16 file loader package
// Shared sizes, result kinds, status codes, config indices and structs.
// ---------------------------------------------------------------------------
package fat16_pkg;
  localparam int unsigned DirSectors  = 2;
  localparam int unsigned RootSectors = 32;
  localparam int unsigned SectorWords = 256;

  localparam logic [1:0] KindRead   = 2'd0;
  localparam logic [1:0] KindStore  = 2'd1;
  localparam logic [1:0] KindFinish = 2'd2;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StEmpty   = 3'd1;
  localparam logic [2:0] StMissing = 3'd2;
  localparam logic [2:0] StShort   = 3'd3;
  localparam logic [2:0] StNoEnd   = 3'd4;

  localparam logic [1:0] CfgNameHead = 2'd0;
  localparam logic [1:0] CfgNameTail = 2'd1;
  localparam logic [1:0] CfgLoadBase = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [27:0] lba;
    logic [7:0]  num_sectors;
    logic [31:0] mem_addr;
    logic [15:0] store_data;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ design/fat16_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// FAT16 radix-2 divider
// Restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
// ---------------------------------------------------------------------------
module fat16_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fat16_pkg::div_req_t req_i,
  output fat16_pkg::div_rsp_t      rsp_o
);
  import fat16_pkg::*;

  logic [31:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

@@ design/fat16_file_loader.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// FAT16 file loader
// Reads the boot sector and root directory, then follows a file's cluster chain.
// ---------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tuser operation, tdata disk_word
// m_axis    out        tuser kind, tdata lba..status, tlast last
// cfg       in         index 0..2, 64-bit write data
// A disk word that causes a store beat stalls the input until that beat is taken.
// After the last boot word the root sector is computed before the directory read beat.
// A found entry starts the divider; the first cluster read follows once it is done.
// A new cluster passes PhLink, then PhClus issues its read; PhFatReq issues a FAT read.
// Reset is asynchronous and clears all control state.
// s_axis_tready stays low while a result beat waits on m_axis_tready or a step runs.
module fat16_file_loader #(
  parameter int unsigned DIR_SECTORS  = fat16_pkg::DirSectors,
  parameter int unsigned ROOT_SECTORS = fat16_pkg::RootSectors
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // disk_word
  input  wire logic        s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // lba, num_sectors, mem_addr, store_data, status
  output logic [1:0]       m_axis_tuser,   // kind
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  import fat16_pkg::*;

  localparam logic [3:0] PhIdle = 4'd0, PhBoot = 4'd1, PhDir = 4'd2, PhData = 4'd3,
                         PhFat = 4'd4, PhRoot = 4'd5, PhDiv = 4'd6, PhClus = 4'd7,
                         PhFatReq = 4'd8, PhLink = 4'd9;
  localparam logic [15:0] DirWords = 16'(DIR_SECTORS * SectorWords);

  logic [63:0] name_head_q;
  logic [23:0] name_tail_q;
  logic [31:0] load_base_q;
  logic [3:0]  phase_q, phase_d;
  logic [15:0] words_left_q, words_left_d;
  logic [7:0]  spc_q, spc_d, fat_copies_q, fat_copies_d;
  logic [15:0] rsv_q, rsv_d, spf_q, spf_d;
  logic [31:0] root_q, root_d;
  logic [3:0]  ew_q, ew_d;
  logic        neq_q, neq_d, found_q, found_d, empty_q, empty_d, cap_q, cap_d;
  logic [31:0] size_q, size_d, addr_q, addr_d;
  logic [15:0] cur_q, cur_d, left_q, left_d, link_q, link_d;
  logic        ov_q, ov_d, ol_q, ol_d, pv_q, pv_d, pl_q, pl_d;
  result_t     o_q, o_d, p_q, p_d;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [31:0] mul_q, mul_d;

  fat16_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  function automatic logic [7:0] nbyte(logic [63:0] h, logic [23:0] t, logic [3:0] k);
    logic [7:0] b;
    if (k < 4'd8) b = h[8*k[2:0] +: 8];
    else          b = t[8*((k[1:0]) == 2'd3 ? 2'd0 : k[1:0]) +: 8];
    return b;
  endfunction

  function automatic result_t rd(logic [27:0] l, logic [7:0] c);
    result_t r;
    r = '0;
    r.kind = KindRead;
    r.lba = l;
    r.num_sectors = c;
    return r;
  endfunction

  function automatic result_t fin(logic [2:0] s);
    result_t r;
    r = '0;
    r.kind = KindFinish;
    r.status = s;
    return r;
  endfunction

  logic busy_out, in_fire, emit_ok;
  logic [7:0]  idx;
  logic [15:0] w;
  logic [3:0]  k0;
  logic [31:0] clus_lba;

  assign busy_out      = ov_q || pv_q;
  assign s_axis_tready = !busy_out && (phase_q == PhIdle || phase_q == PhBoot ||
                         phase_q == PhDir || phase_q == PhData || phase_q == PhFat);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_ok       = !busy_out;
  assign cfg_ready_o   = 1'b1;
  assign idx           = 8'(SectorWords - 32'(words_left_q));
  assign w             = s_axis_tdata;
  assign k0            = {ew_q[2:0], 1'b0};
  assign clus_lba      = root_q + 32'(ROOT_SECTORS) + mul_q;

  always_comb begin
    phase_d = phase_q; words_left_d = words_left_q; spc_d = spc_q; rsv_d = rsv_q;
    fat_copies_d = fat_copies_q; spf_d = spf_q; root_d = root_q; ew_d = ew_q;
    neq_d = neq_q; found_d = found_q; empty_d = empty_q; cap_d = cap_q;
    size_d = size_q; addr_d = addr_q; cur_d = cur_q; left_d = left_q; link_d = link_q;
    ov_d = ov_q; ol_d = ol_q; o_d = o_q; pv_d = pv_q; pl_d = pl_q; p_d = p_q;
    mul_d = mul_q;
    dreq = '0;
    if (ov_q && m_axis_tready) begin
      ov_d = pv_q; ol_d = pl_q; o_d = p_q; pv_d = 1'b0;
    end
    if (in_fire && !s_axis_tuser) begin
      ew_d = '0; neq_d = 1'b1; found_d = 1'b0; empty_d = 1'b0; cap_d = 1'b0;
      size_d = '0; cur_d = '0; left_d = '0; link_d = '0; addr_d = load_base_q;
      phase_d = PhBoot; words_left_d = 16'(SectorWords);
      ov_d = 1'b1; ol_d = 1'b1; o_d = rd('0, 8'd1);
    end else if (in_fire && phase_q != PhIdle && words_left_q != '0) begin
      words_left_d = words_left_q - 16'd1;
      case (phase_q)
        PhBoot: begin
          if (idx == 8'd6) spc_d = w[15:8];
          else if (idx == 8'd7) rsv_d = w;
          else if (idx == 8'd8) fat_copies_d = w[7:0];
          else if (idx == 8'd11) spf_d = w;
          if (words_left_q == 16'd1) phase_d = PhRoot;
        end
        PhDir: begin
          begin : dirw
            logic ne;
            logic cp;
            ne = (ew_q == '0) ? 1'b1 : neq_q;
            cp = (ew_q == '0) ? 1'b0 : cap_q;
            if (!found_q && !empty_q) begin
              if (ew_q == '0 && w[7:0] == '0) empty_d = 1'b1;
              else if (ew_q <= 4'd5) begin
                if (w[7:0] != nbyte(name_head_q, name_tail_q, k0)) ne = 1'b0;
                if (ew_q < 4'd5 && w[15:8] != nbyte(name_head_q, name_tail_q, k0 + 4'd1))
                  ne = 1'b0;
                if (ew_q == 4'd5 && ne) begin
                  found_d = 1'b1; cp = 1'b1;
                end
              end
            end
            if (cp) begin
              if (ew_q == 4'd13) cur_d = w;
              else if (ew_q == 4'd14) size_d = {size_q[31:16], w};
              else if (ew_q == 4'd15) size_d = {w, size_q[15:0]};
            end
            neq_d = ne; cap_d = cp;
          end
          ew_d = ew_q + 4'd1;
          if (words_left_q == 16'd1) phase_d = PhDiv;
        end
        PhData: begin
          o_d = '0; o_d.kind = KindStore; o_d.mem_addr = addr_q; o_d.store_data = w;
          ov_d = 1'b1; ol_d = (words_left_q != 16'd1);
          addr_d = addr_q + 32'd2;
          if (words_left_q == 16'd1) phase_d = PhFatReq;
        end
        default: begin
          if (idx == cur_q[7:0]) link_d = w;
          if (words_left_q == 16'd1) phase_d = PhLink;
        end
      endcase
      if (phase_q == PhDir && words_left_q == 16'd1) begin
        if (empty_d) begin
          phase_d = PhIdle; words_left_d = '0; ov_d = 1'b1; ol_d = 1'b1; o_d = fin(StEmpty);
        end else if (!found_d) begin
          phase_d = PhIdle; words_left_d = '0; ov_d = 1'b1; ol_d = 1'b1;
          o_d = fin(StMissing);
        end else begin
          dreq.start = 1'b1;
          dreq.dividend = size_d - 32'd1;
          dreq.divisor = {15'd0, spc_q, 9'd0};
        end
      end
      if (phase_d == PhFatReq || phase_d == PhRoot || phase_d == PhLink)
        mul_d = 32'(fat_copies_q) * 32'(spf_q);
    end else if (emit_ok) begin
      case (phase_q)
        PhRoot: begin
          root_d = mul_q + 32'(rsv_q);
          phase_d = PhDir; ew_d = '0; words_left_d = DirWords;
          ov_d = 1'b1; ol_d = 1'b1; o_d = rd(28'(mul_q + 32'(rsv_q)), 8'(DIR_SECTORS));
        end
        PhDiv: begin
          if (drsp.done) begin
            left_d = (spc_q == '0) ? 16'd0 : 16'(drsp.quotient + 32'd1);
            mul_d = (32'(cur_q) - 32'd2) * 32'(spc_q);
            phase_d = PhClus;
          end
        end
        PhClus: begin
          ov_d = 1'b1; o_d = rd(28'(clus_lba), spc_q);
          words_left_d = {spc_q, 8'd0};
          if (spc_q == '0) begin
            ol_d = 1'b0; pv_d = 1'b1; pl_d = 1'b1;
            p_d = rd(28'(16'((cur_q >> 8) + rsv_q)), 8'd1);
            phase_d = PhFat; words_left_d = 16'(SectorWords);
          end else begin
            ol_d = 1'b1; phase_d = PhData;
          end
        end
        PhFatReq: begin
          ov_d = 1'b1; ol_d = 1'b1;
          o_d = rd(28'(16'((cur_q >> 8) + rsv_q)), 8'd1);
          phase_d = PhFat; words_left_d = 16'(SectorWords);
        end
        PhLink: begin
          if (link_q >= 16'hfff8) begin
            phase_d = PhIdle; words_left_d = '0; ov_d = 1'b1; ol_d = 1'b1;
            o_d = fin((left_q != 16'd1) ? StShort : StOk);
          end else begin
            cur_d = link_q; left_d = left_q - 16'd1;
            if (left_q == 16'd1) begin
              phase_d = PhIdle; words_left_d = '0; ov_d = 1'b1; ol_d = 1'b1;
              o_d = fin(StNoEnd);
            end else begin
              mul_d = (32'(link_q) - 32'd2) * 32'(spc_q);
              phase_d = PhClus;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_head_q <= '0; name_tail_q <= '0; load_base_q <= '0;
      phase_q <= PhIdle; words_left_q <= '0; spc_q <= '0; rsv_q <= '0;
      fat_copies_q <= '0; spf_q <= '0; root_q <= '0; ew_q <= '0; neq_q <= 1'b1;
      found_q <= 1'b0; empty_q <= 1'b0; cap_q <= 1'b0; size_q <= '0; addr_q <= '0;
      cur_q <= '0; left_q <= '0; link_q <= '0;
      ov_q <= 1'b0; ol_q <= 1'b0; pv_q <= 1'b0; pl_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgNameHead: name_head_q <= cfg_data_i;
          CfgNameTail: name_tail_q <= cfg_data_i[23:0];
          CfgLoadBase: load_base_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      phase_q <= phase_d; words_left_q <= words_left_d; spc_q <= spc_d; rsv_q <= rsv_d;
      fat_copies_q <= fat_copies_d; spf_q <= spf_d; root_q <= root_d; ew_q <= ew_d;
      neq_q <= neq_d; found_q <= found_d; empty_q <= empty_d; cap_q <= cap_d;
      size_q <= size_d; addr_q <= addr_d; cur_q <= cur_d; left_q <= left_d;
      link_q <= link_d; ov_q <= ov_d; ol_q <= ol_d; pv_q <= pv_d; pl_q <= pl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q <= o_d; p_q <= p_d; mul_q <= mul_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = o_q.kind;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tdata  = {1'b0, o_q.status, o_q.store_data, o_q.mem_addr,
                          o_q.num_sectors, o_q.lba};
endmodule
`default_nettype wire
